// ===== rtl/tcgr_pkg.sv =====
// shared types and constants for the text console glyph renderer
// field widths, bus packing positions, register and operation codes
`timescale 1ns / 1ps

package tcgr_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned FontIdxW   = 12;
  localparam int unsigned FontByteW  = 8;
  localparam int unsigned ColW       = 10;
  localparam int unsigned RowW       = 8;
  localparam int unsigned PitchW     = 16;
  localparam int unsigned BppW       = 3;
  localparam int unsigned OffW       = 32;
  localparam int unsigned PixW       = 8;

  // input tdata: char_code, font_index, font_byte, zero fill to 32 bits
  localparam int unsigned InDataW    = 32;
  localparam int unsigned CharLsb    = 0;
  localparam int unsigned FontIdxLsb = CharLsb + CharW;
  localparam int unsigned FontByteLsb = FontIdxLsb + FontIdxW;

  // output tdata: row_offset, pixel_bits
  localparam int unsigned OutDataW   = OffW + PixW;

  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [ColW-1:0]   ColsReset  = 10'd80;
  localparam logic [RowW-1:0]   RowsReset  = 8'd30;
  localparam logic [PitchW-1:0] PitchReset = 16'd1920;
  localparam logic [BppW-1:0]   BppReset   = 3'd3;

  localparam logic [CharW-1:0]  CharNewline = 8'h0a;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEXT_COLUMNS    = 2'd0,
    CFG_TEXT_ROWS       = 2'd1,
    CFG_LINE_PITCH      = 2'd2,
    CFG_BYTES_PER_PIXEL = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef enum logic {
    KIND_GLYPH  = 1'b0,
    KIND_SCROLL = 1'b1
  } kind_e;

endpackage

// ===== rtl/text_console_glyph_renderer.sv =====
// text console glyph renderer: cursor tracking, font memory, glyph row stream
// depends on tcgr_pkg
`timescale 1ns / 1ps

// A printable character yields GLYPH_HEIGHT glyph rows (16 by default), one
// per cycle unless the output stalls, read through the font memory's single
// read port; a character that scrolls adds a scroll request. Font loads and
// newlines that do not scroll give no result. The next item is taken in the
// cycle the previous one issues its final result, so characters stream back
// to back, and an output register lets work continue while a result waits
// for m_axis_tready. The font memory needs no clearing pass after reset.
module text_console_glyph_renderer #(
  parameter int unsigned GLYPH_HEIGHT = 16,
  parameter int unsigned FONT_DEPTH   = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tcgr_pkg::InDataW-1:0]    s_axis_tdata,  // char_code, font_index, font_byte
  input  logic                            s_axis_tuser,  // op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tcgr_pkg::OutDataW-1:0]   m_axis_tdata,  // row_offset, pixel_bits
  output logic                            m_axis_tuser,  // kind
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tcgr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tcgr_pkg::CfgDataW-1:0]   cfg_data_i
);
  import tcgr_pkg::*;

  localparam int unsigned RW  = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
  localparam int unsigned AW  = $clog2(FONT_DEPTH);
  localparam int unsigned GAW = $clog2(256 * GLYPH_HEIGHT);
  localparam int unsigned PW  = GAW + PitchW;
  localparam logic [RW-1:0] LastRow = RW'(GLYPH_HEIGHT - 1);

  typedef enum logic [1:0] {
    GEN_IDLE,
    GEN_ROWS,
    GEN_SCROLL
  } gen_state_e;

  // input unpacking
  op_e                  in_op;
  logic [CharW-1:0]     in_char;
  logic [FontIdxW-1:0]  in_fidx;
  logic [FontByteW-1:0] in_fbyte;

  assign in_op    = op_e'(s_axis_tuser);
  assign in_char  = s_axis_tdata[CharLsb +: CharW];
  assign in_fidx  = s_axis_tdata[FontIdxLsb +: FontIdxW];
  assign in_fbyte = s_axis_tdata[FontByteLsb +: FontByteW];

  // configuration
  logic [ColW-1:0]   cols_q;
  logic [RowW-1:0]   rows_q;
  logic [PitchW-1:0] pitch_q;
  logic [BppW-1:0]   bpp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= ColsReset;
      rows_q  <= RowsReset;
      pitch_q <= PitchReset;
      bpp_q   <= BppReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TEXT_COLUMNS:    cols_q  <= cfg_data_i[ColW-1:0];
        CFG_TEXT_ROWS:       rows_q  <= cfg_data_i[RowW-1:0];
        CFG_LINE_PITCH:      pitch_q <= cfg_data_i[PitchW-1:0];
        CFG_BYTES_PER_PIXEL: bpp_q   <= cfg_data_i[BppW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshakes
  gen_state_e    state_q;
  logic          b_valid_q;
  logic          out_valid_q;
  logic          out_free;
  logic          b_move;
  logic          issue_ok;
  logic          step;
  logic          step_last;
  logic          gen_finish;
  logic          s_acc;
  logic          draw_acc;
  logic          load_acc;
  logic          scroll_q;
  logic [RW-1:0] r_q;

  assign out_free   = !out_valid_q || m_axis_tready;
  assign b_move     = b_valid_q && out_free;
  assign issue_ok   = !b_valid_q || b_move;
  assign step       = issue_ok && (state_q != GEN_IDLE);
  assign step_last  = (state_q == GEN_ROWS && r_q == LastRow && !scroll_q) ||
                      (state_q == GEN_SCROLL);
  assign gen_finish = step && step_last;

  assign s_axis_tready = (state_q == GEN_IDLE) || gen_finish;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign draw_acc      = s_acc && (in_op == OP_DRAW);
  assign load_acc      = s_acc && (in_op == OP_LOAD);

  // cursor update
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [ColW:0]   col_nxt;
  logic [RowW:0]   row_nxt;
  logic [RowW-1:0] row_limit;
  logic            scroll_d;
  logic            is_newline;

  assign is_newline = (in_char == CharNewline);

  always_comb begin
    col_nxt = {1'b0, col_q} + (ColW+1)'(1);
    row_nxt = {1'b0, row_q};
    if (is_newline) begin
      col_nxt = '0;
      row_nxt = row_nxt + (RowW+1)'(1);
    end
    if (col_nxt >= {1'b0, cols_q}) begin
      col_nxt = '0;
      row_nxt = row_nxt + (RowW+1)'(1);
    end
    row_limit = (rows_q < 8'd2) ? 8'd1 : rows_q - 8'd1;
    scroll_d  = (row_nxt >= {1'b0, row_limit});
    if (scroll_d) begin
      row_nxt = row_nxt - (RowW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (draw_acc) begin
      col_q <= col_nxt[ColW-1:0];
      row_q <= row_nxt[RowW-1:0];
    end
  end

  // row sequencer
  logic [GAW-1:0]  base_q;
  logic [GAW-1:0]  ypix_q;
  logic [ColW-1:0] gcol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GEN_IDLE;
    end else if (draw_acc) begin
      if (!is_newline) begin
        state_q <= GEN_ROWS;
      end else if (scroll_d) begin
        state_q <= GEN_SCROLL;
      end else begin
        state_q <= GEN_IDLE;
      end
    end else if (step) begin
      case (state_q)
        GEN_ROWS: begin
          if (r_q == LastRow) begin
            state_q <= scroll_q ? GEN_SCROLL : GEN_IDLE;
          end
        end
        GEN_SCROLL: state_q <= GEN_IDLE;
        default:    state_q <= GEN_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw_acc) begin
      r_q      <= '0;
      base_q   <= GAW'(in_char) * GAW'(GLYPH_HEIGHT);
      ypix_q   <= GAW'(row_q) * GAW'(GLYPH_HEIGHT);
      gcol_q   <= col_q;
      scroll_q <= scroll_d;
    end else if (step && state_q == GEN_ROWS) begin
      r_q    <= r_q + RW'(1);
      ypix_q <= ypix_q + GAW'(1);
    end
  end

  // font memory
  logic [FontByteW-1:0] font_mem [FONT_DEPTH];
  logic [FontByteW-1:0] rdata_q;
  logic                 rd_en;
  logic [GAW-1:0]       rd_full;
  logic                 rd_oob;
  logic                 mem_we;

  assign rd_en   = step && (state_q == GEN_ROWS);
  assign rd_full = base_q + GAW'(r_q);
  assign rd_oob  = !({1'b0, rd_full} < (GAW+1)'(FONT_DEPTH));
  assign mem_we  = load_acc && ({1'b0, in_fidx} < (FontIdxW+1)'(FONT_DEPTH));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      font_mem[AW'(in_fidx)] <= in_fbyte;
    end
    if (rd_en) begin
      rdata_q <= font_mem[AW'(rd_full)];
    end
  end

  // offset of the glyph row
  logic [PW-1:0]        ypix_prod;
  logic [ColW+BppW-1:0] col_prod;
  logic [OffW-1:0]      row_off;

  assign ypix_prod = PW'(ypix_q) * PW'(pitch_q);
  assign col_prod  = (ColW+BppW)'(gcol_q) * (ColW+BppW)'(bpp_q);
  assign row_off   = OffW'(ypix_prod) + OffW'({col_prod, 3'b000});

  // read data stage
  kind_e           b_kind_q;
  logic [OffW-1:0] b_off_q;
  logic            b_zero_q;
  logic            b_last_q;
  logic [PixW-1:0] b_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (issue_ok) begin
      b_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      b_kind_q <= (state_q == GEN_SCROLL) ? KIND_SCROLL : KIND_GLYPH;
      b_off_q  <= (state_q == GEN_SCROLL) ? '0 : row_off;
      b_zero_q <= (state_q == GEN_SCROLL) || rd_oob;
      b_last_q <= step_last;
    end
  end

  assign b_pix = b_zero_q ? '0 : rdata_q;

  // output register
  kind_e           o_kind_q;
  logic [OffW-1:0] o_off_q;
  logic [PixW-1:0] o_pix_q;
  logic            o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_move) begin
      o_kind_q <= b_kind_q;
      o_off_q  <= b_off_q;
      o_pix_q  <= b_pix;
      o_last_q <= b_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {o_pix_q, o_off_q};
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;

  // checks
  a_accept_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && state_q != GEN_IDLE) |-> gen_finish)
    else $error("item accepted while glyph rows still pending");

  a_scroll_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_kind_q == KIND_SCROLL) |-> b_last_q)
    else $error("scroll request not marked as final result");

  a_column_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_acc |=> (col_q == '0 || col_q < $past(cols_q)))
    else $error("cursor column left at or beyond column limit");

  a_scroll_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_SCROLL) |-> (m_axis_tdata == '0 && m_axis_tlast))
    else $error("scroll request carries payload");

endmodule
